/* src/v3alu_pkg.sv */
// ----------------------------------------------------------------------------
// v3alu_pkg
// Widths, opcodes, pipeline payload types and saturation for the 3-vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

  localparam int WORD_WIDTH   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_W       = 2 * WORD_WIDTH;
  localparam int SHP_W        = PROD_W - FRAC_BITS;
  localparam int EXT_W        = SHP_W + 4;
  localparam int REM_W        = PROD_W + 2;
  localparam int NUM_W        = WORD_WIDTH + FRAC_BITS;
  localparam int DREM_W       = NUM_W + 1;
  localparam int Q_W          = FRAC_BITS + 1;
  localparam int FRONT_STAGES = 2;
  localparam int SQRT_STAGES  = WORD_WIDTH;
  localparam int DIV_STAGES   = Q_W;
  localparam int PIPE_STAGES  = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic [WORD_WIDTH-1:0]        mag_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SHP_W-1:0]      shp_t;
  typedef logic signed [EXT_W-1:0]      ext_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CROSS = 4'd2,
    OP_PERP  = 4'd3,
    OP_DOT   = 4'd4,
    OP_LEN   = 4'd5,
    OP_SCALE = 4'd6,
    OP_NEG   = 4'd7,
    OP_NORM  = 4'd8
  } op_t;

  typedef struct packed {
    op_t   opcode;
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t scalar;
    logic  ov;
  } res_t;

  typedef struct packed {
    res_t             res;
    logic [2:0]       neg;
    mag_t [2:0]       mag;
    logic [REM_W-1:0] rem;
    mag_t             root;
  } sq_t;

  typedef struct packed {
    res_t                   res;
    logic [2:0]             neg;
    logic [2:0][DREM_W-1:0] rem;
    logic [2:0][Q_W-1:0]    q;
    mag_t                   den;
  } dv_t;

  typedef struct packed {
    word_t val;
    logic  ov;
  } sat_t;

  function automatic sat_t saturate(input ext_t v);
    sat_t                       s;
    logic [EXT_W-WORD_WIDTH:0]  top;
    top = v[EXT_W-1:WORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      s.val = v[WORD_WIDTH-1:0];
      s.ov  = 1'b0;
    end else begin
      s.val = v[EXT_W-1] ? WORD_MIN : WORD_MAX;
      s.ov  = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/v3alu_front.sv */
// ----------------------------------------------------------------------------
// v3alu_front
// Two stages: six shared multipliers, then sums, differences, saturation and
// the start of the square root for length and normalize.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_front (
  input  logic                clk,
  input  logic                advance,
  input  v3alu_pkg::op_t      opcode,
  input  v3alu_pkg::word_t    a [3],
  input  v3alu_pkg::word_t    b [3],
  input  v3alu_pkg::word_t    s,
  output v3alu_pkg::sq_t      out_data
);
  import v3alu_pkg::*;

  word_t ma [6];
  word_t mb [6];
  prod_t p_n [6];

  op_t   op1;
  word_t a1 [3];
  word_t b1 [3];
  prod_t p1 [6];

  shp_t  sh [6];
  ext_t  ea [3];
  ext_t  eb [3];
  ext_t  es [6];
  mag_t  mg [3];
  ext_t  v [3];
  ext_t  sc;
  sat_t  sx, sy, sz, ssc;
  logic [PROD_W-1:0] sumsq;
  sq_t   stage2_next;

  always_comb begin
    ma[0] = a[1]; mb[0] = b[2];
    ma[1] = a[2]; mb[1] = b[1];
    ma[2] = a[2]; mb[2] = b[0];
    ma[3] = a[0]; mb[3] = b[2];
    ma[4] = a[0]; mb[4] = b[1];
    ma[5] = a[1]; mb[5] = b[0];
    case (opcode) inside
      OP_DOT: begin
        ma[0] = a[0]; mb[0] = b[0];
        ma[1] = a[1]; mb[1] = b[1];
        ma[2] = a[2]; mb[2] = b[2];
      end
      OP_SCALE: begin
        ma[0] = a[0]; mb[0] = s;
        ma[1] = a[1]; mb[1] = s;
        ma[2] = a[2]; mb[2] = s;
      end
      OP_LEN, OP_NORM: begin
        ma[0] = a[0]; mb[0] = a[0];
        ma[1] = a[1]; mb[1] = a[1];
        ma[2] = a[2]; mb[2] = a[2];
      end
      default: begin
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      p_n[k] = ma[k] * mb[k];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op1 <= opcode;
      a1  <= a;
      b1  <= b;
      p1  <= p_n;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sh[k] = p1[k][PROD_W-1:FRAC_BITS];
      es[k] = EXT_W'(sh[k]);
    end
    for (int k = 0; k < 3; k++) begin
      ea[k] = EXT_W'(a1[k]);
      eb[k] = EXT_W'(b1[k]);
      mg[k] = a1[k][WORD_WIDTH-1] ? mag_t'(-a1[k]) : mag_t'(a1[k]);
      v[k]  = '0;
    end
    sc    = '0;
    sumsq = p1[0] + p1[1] + p1[2];
    unique case (op1)
      OP_ADD: for (int k = 0; k < 3; k++) v[k] = ea[k] + eb[k];
      OP_SUB: for (int k = 0; k < 3; k++) v[k] = ea[k] - eb[k];
      OP_CROSS: begin
        v[0] = es[0] - es[1];
        v[1] = es[2] - es[3];
        v[2] = es[4] - es[5];
      end
      OP_PERP: begin
        if (mg[0] <= mg[1] && mg[0] <= mg[2]) begin
          v[1] = ea[2];
          v[2] = -ea[1];
        end else if (mg[1] <= mg[2]) begin
          v[0] = -ea[2];
          v[2] = ea[0];
        end else begin
          v[0] = ea[1];
          v[1] = -ea[0];
        end
      end
      OP_DOT:   sc = es[0] + es[1] + es[2];
      OP_SCALE: for (int k = 0; k < 3; k++) v[k] = es[k];
      OP_NEG:   for (int k = 0; k < 3; k++) v[k] = -ea[k];
      default: begin
      end
    endcase
    sx  = saturate(v[0]);
    sy  = saturate(v[1]);
    sz  = saturate(v[2]);
    ssc = saturate(sc);
    stage2_next.res.opcode = op1;
    stage2_next.res.r_x    = sx.val;
    stage2_next.res.r_y    = sy.val;
    stage2_next.res.r_z    = sz.val;
    stage2_next.res.scalar = ssc.val;
    stage2_next.res.ov     = sx.ov | sy.ov | sz.ov | ssc.ov;
    for (int k = 0; k < 3; k++) begin
      stage2_next.neg[k] = a1[k][WORD_WIDTH-1];
      stage2_next.mag[k] = mg[k];
    end
    stage2_next.rem  = REM_W'(sumsq);
    stage2_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= stage2_next;
    end
  end

endmodule

`default_nettype wire

/* src/v3alu_sqrt.sv */
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root, one root bit per stage, most significant
// bit first, on the sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_sqrt (
  input  logic            clk,
  input  logic            advance,
  input  v3alu_pkg::sq_t  in_data,
  output v3alu_pkg::sq_t  out_data
);
  import v3alu_pkg::*;

  sq_t stage [SQRT_STAGES];
  sq_t src [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_bit
    localparam int BIT = WORD_WIDTH - 1 - k;
    sq_t              nxt;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src[k] = in_data;
    end else begin : g_rest
      assign src[k] = stage[k-1];
    end

    always_comb begin
      trial = (REM_W'(src[k].root) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
      nxt   = src[k];
      if (src[k].rem >= trial) begin
        nxt.rem  = src[k].rem - trial;
        nxt.root = src[k].root | (mag_t'(1) << BIT);
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage[k] <= nxt;
      end
    end
  end

  assign out_data = stage[SQRT_STAGES-1];

endmodule

`default_nettype wire

/* src/v3alu_div.sv */
// ----------------------------------------------------------------------------
// v3alu_div
// Length saturation, then a pipelined restoring divider, one quotient bit per
// stage, three lanes for the normalized components.
// ----------------------------------------------------------------------------
`default_nettype none

module v3alu_div (
  input  logic            clk,
  input  logic            advance,
  input  v3alu_pkg::sq_t  in_data,
  output v3alu_pkg::dv_t  out_data
);
  import v3alu_pkg::*;

  dv_t prep;
  dv_t stage [DIV_STAGES];
  dv_t src [DIV_STAGES];

  always_comb begin
    prep.res = in_data.res;
    if (in_data.res.opcode == OP_LEN) begin
      if (in_data.root[WORD_WIDTH-1]) begin
        prep.res.scalar = WORD_MAX;
        prep.res.ov     = 1'b1;
      end else begin
        prep.res.scalar = in_data.root;
      end
    end
    prep.den = (in_data.root == '0) ? (mag_t'(1) << FRAC_BITS) : in_data.root;
    prep.neg = in_data.neg;
    prep.q   = '0;
    for (int j = 0; j < 3; j++) begin
      prep.rem[j] = {1'b0, in_data.mag[j], {FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_bit
    localparam int BIT = FRAC_BITS - k;
    dv_t               nxt;
    logic [DREM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src[k] = prep;
    end else begin : g_rest
      assign src[k] = stage[k-1];
    end

    always_comb begin
      trial = DREM_W'(src[k].den) << BIT;
      nxt   = src[k];
      for (int j = 0; j < 3; j++) begin
        if (src[k].rem[j] >= trial) begin
          nxt.rem[j] = src[k].rem[j] - trial;
          nxt.q[j]   = src[k].q[j] | (Q_W'(1) << BIT);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage[k] <= nxt;
      end
    end
  end

  assign out_data = stage[DIV_STAGES-1];

endmodule

`default_nettype wire

/* src/vector3_alu_unit.sv */
// ----------------------------------------------------------------------------
// vector3_alu_unit
// Signed Q16.16 3-vector unit: add, sub, cross, perpendicular, dot, length,
// scale, negate, normalize, with saturation and an overflow flag.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  opcode, a_x..a_z, b_x..b_z, scale_factor
//   out      out_valid/out_stall  r_x, r_y, r_z, scalar_out, overflow
//
// One item per cycle while the skid register is empty. The path from acceptance
// to output is 2 multiply/combine stages, 32 square root stages, 17 divider
// stages and an output register; depth is set by the one-bit-per-stage root
// and divider. Reset clears only the valid bits and the skid valid flag.
// A skid register takes one item when out_stall is high; the pipeline holds
// and in_stall is raised while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_alu_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [3:0]                               opcode,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  a_x,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  a_y,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  a_z,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  b_x,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  b_y,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  b_z,
  input  logic signed [v3alu_pkg::WORD_WIDTH-1:0]  scale_factor,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [v3alu_pkg::WORD_WIDTH-1:0]  r_x,
  output logic signed [v3alu_pkg::WORD_WIDTH-1:0]  r_y,
  output logic signed [v3alu_pkg::WORD_WIDTH-1:0]  r_z,
  output logic signed [v3alu_pkg::WORD_WIDTH-1:0]  scalar_out,
  output logic                                     overflow
);
  import v3alu_pkg::*;

  logic                   advance;
  logic [PIPE_STAGES-1:0] valid;
  logic                   skid_valid;
  word_t                  a_vec [3];
  word_t                  b_vec [3];
  sq_t                    front_out;
  sq_t                    sqrt_out;
  dv_t                    div_out;
  res_t                   fin;
  res_t                   last;
  res_t                   skid;
  res_t                   shown;
  word_t                  qw;

  assign a_vec[0] = a_x;
  assign a_vec[1] = a_y;
  assign a_vec[2] = a_z;
  assign b_vec[0] = b_x;
  assign b_vec[1] = b_y;
  assign b_vec[2] = b_z;

  assign advance  = !skid_valid;
  assign in_stall = skid_valid;

  v3alu_front u_front (
    .clk      (clk),
    .advance  (advance),
    .opcode   (op_t'(opcode)),
    .a        (a_vec),
    .b        (b_vec),
    .s        (scale_factor),
    .out_data (front_out)
  );

  v3alu_sqrt u_sqrt (
    .clk      (clk),
    .advance  (advance),
    .in_data  (front_out),
    .out_data (sqrt_out)
  );

  v3alu_div u_div (
    .clk      (clk),
    .advance  (advance),
    .in_data  (sqrt_out),
    .out_data (div_out)
  );

  always_comb begin
    fin = div_out.res;
    qw  = '0;
    if (div_out.res.opcode == OP_NORM) begin
      qw      = word_t'(div_out.q[0]);
      fin.r_x = div_out.neg[0] ? -qw : qw;
      qw      = word_t'(div_out.q[1]);
      fin.r_y = div_out.neg[1] ? -qw : qw;
      qw      = word_t'(div_out.q[2]);
      fin.r_z = div_out.neg[2] ? -qw : qw;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last <= fin;
    end
    if (!skid_valid) begin
      skid <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      skid_valid <= 1'b0;
    end else begin
      if (advance) begin
        valid <= {valid[PIPE_STAGES-2:0], in_valid};
      end
      if (skid_valid) begin
        if (!out_stall) begin
          skid_valid <= 1'b0;
        end
      end else if (valid[PIPE_STAGES-1] && out_stall) begin
        skid_valid <= 1'b1;
      end
    end
  end

  assign shown      = skid_valid ? skid : last;
  assign out_valid  = skid_valid | valid[PIPE_STAGES-1];
  assign r_x        = shown.r_x;
  assign r_y        = shown.r_y;
  assign r_z        = shown.r_z;
  assign scalar_out = shown.scalar;
  assign overflow   = shown.ov;

  a_skid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(valid[PIPE_STAGES-1] && out_stall))
    else $error("skid loaded without a stalled output item");

  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held off with no output item pending");

  a_norm_no_ov: assert property (@(posedge clk) disable iff (rst)
    (valid[PIPE_STAGES-1] && last.opcode == OP_NORM) |-> !last.ov)
    else $error("normalize item flagged overflow");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// vector3_alu_unit testbench
// Drives directed and random Q16.16 vector operations through the unit with
// random idling on both channels, predicts every result bit for bit and
// compares each output item field by field in order of acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import v3alu_pkg::*;

  localparam int N_RANDOM  = 1800;
  localparam int LATENCY   = PIPE_STAGES + 4;
  localparam int WD_LIMIT  = 4000;

  typedef struct {
    logic [3:0] op;
    word_t      ax, ay, az, bx, by, bz, sf;
  } vec_item_t;

  typedef struct packed {
    word_t rx, ry, rz, sc;
    logic  ov;
  } vec_result_t;

  typedef struct {
    vec_item_t   it;
    logic        known;
    vec_result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] opcode = '0;
  word_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
  word_t scale_factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t r_x, r_y, r_z, scalar_out;
  logic overflow;

  vec_result_t results_pending[$];
  int  n_fail = 0;
  int  n_checked = 0;
  int  idle_cycles = 0;
  logic quiet_out = 1'b0;
  logic [8:0] ops_seen = '0;

  always #4 clk = ~clk;

  vector3_alu_unit uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .scale_factor(scale_factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .scalar_out(scalar_out), .overflow(overflow)
  );

  function automatic word_t clamp_word(input logic signed [127:0] v, inout logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return WORD_MAX;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] fixed_mul(input word_t x, input word_t y);
    logic signed [127:0] p;
    p = 128'(signed'(x)) * 128'(signed'(y));
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [127:0] norm_of(input word_t x, input word_t y, input word_t z);
    logic signed [127:0] sx, sy, sz;
    sx = 128'(signed'(x));
    sy = 128'(signed'(y));
    sz = 128'(signed'(z));
    return floor_sqrt(sx * sx + sy * sy + sz * sz);
  endfunction

  function automatic vec_result_t predict_vector_op(input vec_item_t t);
    vec_result_t r;
    logic signed [127:0] v[3];
    logic signed [127:0] av[3], bv[3];
    logic signed [127:0] m[3];
    logic [127:0] len, q, num;
    logic is_vec, ov;
    int axis;
    r = '{default: '0};
    ov = 1'b0;
    is_vec = 1'b1;
    av[0] = 128'(signed'(t.ax)); av[1] = 128'(signed'(t.ay)); av[2] = 128'(signed'(t.az));
    bv[0] = 128'(signed'(t.bx)); bv[1] = 128'(signed'(t.by)); bv[2] = 128'(signed'(t.bz));
    for (int i = 0; i < 3; i++) v[i] = '0;
    case (t.op)
      OP_ADD:  for (int i = 0; i < 3; i++) v[i] = av[i] + bv[i];
      OP_SUB:  for (int i = 0; i < 3; i++) v[i] = av[i] - bv[i];
      OP_CROSS: begin
        v[0] = fixed_mul(t.ay, t.bz) - fixed_mul(t.az, t.by);
        v[1] = fixed_mul(t.az, t.bx) - fixed_mul(t.ax, t.bz);
        v[2] = fixed_mul(t.ax, t.by) - fixed_mul(t.ay, t.bx);
      end
      OP_PERP: begin
        for (int i = 0; i < 3; i++) m[i] = av[i] < 0 ? -av[i] : av[i];
        axis = 0;
        if (m[1] < m[axis]) axis = 1;
        if (m[2] < m[axis]) axis = 2;
        case (axis)
          0: begin v[1] = av[2]; v[2] = -av[1]; end
          1: begin v[0] = -av[2]; v[2] = av[0]; end
          default: begin v[0] = av[1]; v[1] = -av[0]; end
        endcase
      end
      OP_DOT: begin
        is_vec = 1'b0;
        r.sc = clamp_word(fixed_mul(t.ax, t.bx) + fixed_mul(t.ay, t.by)
                          + fixed_mul(t.az, t.bz), ov);
      end
      OP_LEN: begin
        is_vec = 1'b0;
        r.sc = clamp_word(signed'(norm_of(t.ax, t.ay, t.az)), ov);
      end
      OP_SCALE: begin
        v[0] = fixed_mul(t.ax, t.sf);
        v[1] = fixed_mul(t.ay, t.sf);
        v[2] = fixed_mul(t.az, t.sf);
      end
      OP_NEG:  for (int i = 0; i < 3; i++) v[i] = -av[i];
      OP_NORM: begin
        len = norm_of(t.ax, t.ay, t.az);
        if (len == 0) len = 128'd1 << FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
          num = (av[i] < 0 ? -av[i] : av[i]) << FRAC_BITS;
          q = num / len;
          if (q >= (128'd1 << (FRAC_BITS + 1))) q = (128'd1 << (FRAC_BITS + 1)) - 1;
          v[i] = av[i] < 0 ? -signed'(q) : signed'(q);
        end
      end
      default: is_vec = 1'b0;
    endcase
    if (is_vec) begin
      r.rx = clamp_word(v[0], ov);
      r.ry = clamp_word(v[1], ov);
      r.rz = clamp_word(v[2], ov);
    end
    r.ov = ov;
    return r;
  endfunction

  function automatic word_t rand_component();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3, 4: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      5, 6: return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic vec_item_t rand_item();
    vec_item_t t;
    t.op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    t.ax = rand_component(); t.ay = rand_component(); t.az = rand_component();
    t.bx = rand_component(); t.by = rand_component(); t.bz = rand_component();
    t.sf = rand_component();
    if (t.op == OP_PERP && $urandom_range(0, 2) == 0) begin
      t.ay = $urandom_range(0, 1) ? t.ax : -t.ax;
      if ($urandom_range(0, 1)) t.az = t.ay;
    end
    return t;
  endfunction

  // hold the item until the unit takes it, with random idling beforehand when may_idle is set
  task automatic send_item(input vec_item_t t, input logic may_idle);
    while (may_idle && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= t.op;
    a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
    b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
    scale_factor <= t.sf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_pending.push_back(predict_vector_op(t));
    if (t.op <= OP_NORM) ops_seen[t.op] = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act);
    if (exp_v !== act) begin
      $error("%s: expected %h, actual %h", name, exp_v, act);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      vec_result_t e;
      if (results_pending.size() == 0) begin
        $error("output item with no expectation waiting");
        n_fail++;
      end else begin
        e = results_pending.pop_front();
        check_field("r_x", e.rx, r_x);
        check_field("r_y", e.ry, r_y);
        check_field("r_z", e.rz, r_z);
        check_field("scalar_out", e.sc, scalar_out);
        check_field("overflow", 32'(e.ov), 32'(overflow));
        n_checked++;
      end
    end
    out_stall <= quiet_out ? 1'b0 : ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_row(input logic [3:0] op, input word_t ax, ay, az, bx, by, bz, sf,
                         input logic known = 1'b0, input word_t rx = 0, ry = 0, rz = 0,
                         input word_t sc = 0, input logic ov = 1'b0);
    row_t r;
    r.it = '{op, ax, ay, az, bx, by, bz, sf};
    r.known = known;
    r.res = '{rx, ry, rz, sc, ov};
    rows.push_back(r);
  endtask

  initial begin
    vec_result_t p;
    add_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(OP_ADD, WORD_MAX, WORD_MIN, 1, 1, -1, 2, 0, 1, WORD_MAX, WORD_MIN, 3, 0, 1);
    add_row(OP_SUB, WORD_MIN, WORD_MAX, 5, 1, -1, 5, 0, 1, WORD_MIN, WORD_MAX, 0, 0, 1);
    add_row(OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 1, 0, 0, 32'sh10000, 0, 0);
    add_row(OP_CROSS, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 0);
    add_row(OP_CROSS, -1, 3, -7, 5, -1, 2, 0);
    add_row(OP_PERP, 5, 5, 5, 0, 0, 0, 0, 1, 0, 5, -5, 0, 0);
    add_row(OP_PERP, 9, -2, 2, 0, 0, 0, 0, 1, -2, 0, 9, 0, 0);
    add_row(OP_PERP, 9, 8, -1, 0, 0, 0, 0, 1, 8, -9, 0, 0, 0);
    add_row(OP_PERP, 0, WORD_MIN, WORD_MIN, 0, 0, 0, 0, 1, 0, WORD_MIN, WORD_MAX, 0, 1);
    add_row(OP_DOT, 32'sh20000, 0, 0, 32'sh30000, 0, 0, 0, 1, 0, 0, 0, 32'sh60000, 0);
    add_row(OP_DOT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 0,
            1, 0, 0, 0, WORD_MAX, 1);
    add_row(OP_DOT, -1, -1, -1, 1, 1, 1, 0);
    add_row(OP_LEN, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'sh50000, 0);
    add_row(OP_LEN, WORD_MIN, WORD_MIN, WORD_MIN, 0, 0, 0, 0, 1, 0, 0, 0, WORD_MAX, 1);
    add_row(OP_SCALE, 32'sh10000, -32'sh20000, 3, 0, 0, 0, 32'sh20000,
            1, 32'sh20000, -32'sh40000, 6, 0, 0);
    add_row(OP_SCALE, WORD_MIN, WORD_MAX, -1, 0, 0, 0, WORD_MIN);
    add_row(OP_NEG, WORD_MIN, WORD_MAX, 0, 0, 0, 0, 0, 1, WORD_MAX, WORD_MIN + 1, 0, 0, 1);
    add_row(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    add_row(OP_NORM, -32'sh30000, 0, 0, 0, 0, 0, 0, 1, -32'sh10000, 0, 0, 0, 0);
    add_row(OP_NORM, 1, -1, WORD_MIN, 0, 0, 0, 0);
    add_row(OP_NORM, WORD_MAX, WORD_MAX, 32'sh30000, 0, 0, 0, 0);
    add_row(4'd9, 1, 2, 3, 4, 5, 6, 7, 1, 0, 0, 0, 0, 0);
    add_row(4'd15, -1, -1, -1, -1, -1, -1, -1, 1, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      p = predict_vector_op(rows[i].it);
      if (rows[i].known && p != rows[i].res) begin
        $error("table row %0d disagrees with prediction", i);
        n_fail++;
      end
      send_item(rows[i].it, 1'b1);
    end

    in_valid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 600) quiet_out <= 1'b1;
      if (n == 900) quiet_out <= 1'b0;
      send_item(rand_item(), !(n >= 600 && n < 900));
    end
    in_valid <= 1'b0;

    while (results_pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("covered %0d results over opcodes %b, saturation and undefined codes",
             n_checked, ops_seen);
    $display("random idling on both channels, one stretch of full throughput");
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
src/v3alu_pkg.sv
src/v3alu_front.sv
src/v3alu_sqrt.sv
src/v3alu_div.sv
src/vector3_alu_unit.sv
sim/testbench.sv
